>>> rtl/core/cbbf_pkg.sv
// ----------------------------------------------------------------------------
// cbbf_pkg
// Shared constants, control word types and the microcode program of the
// cascaded biquad band-pass filter.
// ----------------------------------------------------------------------------
package cbbf_pkg;

	// Default configuration of the filter
	localparam int SECTIONS_DEF  = 4;
	localparam int FRAC_BITS_DEF = 8;

	// Fixed field widths
	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 16;
	localparam int DATA_W        = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int NUM_COEF_REGS = 4;
	localparam int STEP_W        = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SECTION_ONE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd4;

	// Program steps of one section
	localparam logic [STEP_W-1:0] STEP_A1D1  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_A2D2  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_B1D1  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_B2D2  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_SHIFT = 3'd4;
	localparam logic [STEP_W-1:0] STEP_GAIN  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_OUT   = 3'd6;

	// Multiplier operand selects
	typedef enum logic [2:0] {
		MA_A1,
		MA_A2,
		MA_B1,
		MA_B2,
		MA_GAIN
	} mul_a_sel_t;

	typedef enum logic [1:0] {
		MB_D1,
		MB_D2,
		MB_BSUM
	} mul_b_sel_t;

	// Accumulator operations
	typedef enum logic [1:0] {
		W_HOLD,
		W_LOAD_X,
		W_SUB
	} w_op_t;

	typedef enum logic [1:0] {
		B_HOLD,
		B_LOAD,
		B_ADD
	} b_op_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	// One control word of the program
	typedef struct packed {
		mul_a_sel_t mul_a;
		mul_b_sel_t mul_b;
		logic       mul_en;
		w_op_t      w_op;
		b_op_t      b_op;
		logic       shift_delays;
		logic       x_load;
		logic       end_section;
	} ucode_t;

	// Control from the sequencer to the datapath
	typedef struct packed {
		ucode_t uc;
		logic   exec;
		logic   finish;
		logic   busy;
	} seq_ctl_t;

	localparam ucode_t UC_NOP = '{
		mul_a: MA_A1,
		mul_b: MB_D1,
		mul_en: 1'b0,
		w_op: W_HOLD,
		b_op: B_HOLD,
		shift_delays: 1'b0,
		x_load: 1'b0,
		end_section: 1'b0
	};

	// Program ROM: one section of the cascade, replayed per section
	function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
		ucode_t uc;
		uc = UC_NOP;
		unique case (step)
			STEP_A1D1: begin
				uc.mul_a  = MA_A1;
				uc.mul_b  = MB_D1;
				uc.mul_en = 1'b1;
				uc.w_op   = W_LOAD_X;
			end
			STEP_A2D2: begin
				uc.mul_a  = MA_A2;
				uc.mul_b  = MB_D2;
				uc.mul_en = 1'b1;
				uc.w_op   = W_SUB;
			end
			STEP_B1D1: begin
				uc.mul_a  = MA_B1;
				uc.mul_b  = MB_D1;
				uc.mul_en = 1'b1;
				uc.w_op   = W_SUB;
			end
			STEP_B2D2: begin
				uc.mul_a  = MA_B2;
				uc.mul_b  = MB_D2;
				uc.mul_en = 1'b1;
				uc.b_op   = B_LOAD;
			end
			STEP_SHIFT: begin
				uc.b_op         = B_ADD;
				uc.shift_delays = 1'b1;
			end
			STEP_GAIN: begin
				uc.mul_a  = MA_GAIN;
				uc.mul_b  = MB_BSUM;
				uc.mul_en = 1'b1;
			end
			STEP_OUT: begin
				uc.x_load      = 1'b1;
				uc.end_section = 1'b1;
			end
			default: begin
				uc = UC_NOP;
			end
		endcase
		return uc;
	endfunction

endpackage

>>> rtl/core/cbbf_seq.sv
// ----------------------------------------------------------------------------
// cbbf_seq
// Microcode sequencer: step counter over the section program, section
// counter, and the conditional jump back to the first step.
// ----------------------------------------------------------------------------
module cbbf_seq #(
	parameter int SECTIONS = cbbf_pkg::SECTIONS_DEF,
	parameter int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                out_hold,
	output cbbf_pkg::seq_ctl_t  ctl,
	output logic [SEC_W-1:0]    sec_idx
);
	import cbbf_pkg::*;

	seq_state_t          state_q, state_d;
	logic [STEP_W-1:0]   step_q, step_d;
	logic [SEC_W-1:0]    sec_q, sec_d;
	ucode_t              uc;
	logic                last_sec;

	// Fetch the control word of the current step
	assign uc       = ucode_rom(step_q);
	assign last_sec = (sec_q == SEC_W'(SECTIONS - 1));
	assign sec_idx  = sec_q;

	// Hold state, step and section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_A1D1;
			sec_q   <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sec_q   <= sec_d;
		end
	end

	// Advance the program; stall on the final step of the last section while the output is held
	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		sec_d      = sec_q;
		ctl.uc     = uc;
		ctl.exec   = 1'b0;
		ctl.finish = 1'b0;
		ctl.busy   = (state_q == ST_RUN);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RUN;
					step_d  = STEP_A1D1;
					sec_d   = '0;
				end
			end
			ST_RUN: begin
				if (!(uc.end_section && last_sec && out_hold)) begin
					ctl.exec = 1'b1;
					if (uc.end_section) begin
						step_d = STEP_A1D1;
						if (last_sec) begin
							ctl.finish = 1'b1;
							state_d    = ST_IDLE;
						end else begin
							sec_d = sec_q + 1'b1;
						end
					end else begin
						step_d = step_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/cascaded_biquad_bandpass_filter_top.sv
// A result is registered into the output register on the final step of the last section.
// A new sample is taken only while the sequencer is idle; the pace is set by the single
// shared 16x32 multiplier, which forms five products per section over a seven-step program.
// The final step stalls while an earlier result still waits in the output register.
// Reset clears coefficients, gain, all section delays, the sequencer and the output valid.
// ----------------------------------------------------------------------------
// cascaded_biquad_bandpass_filter_top
// Cascade of direct form 2 biquad sections, wrapping 32-bit fixed point,
// run by a microcoded sequencer over one shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module cascaded_biquad_bandpass_filter_top #(
	parameter int SECTIONS  = cbbf_pkg::SECTIONS_DEF,
	parameter int FRAC_BITS = cbbf_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cbbf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cbbf_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [cbbf_pkg::SAMPLE_W-1:0]  sample,
	output logic                                  filtered_valid,
	input  logic                                  filtered_ready,
	output logic signed [cbbf_pkg::DATA_W-1:0]    filtered
);
	import cbbf_pkg::*;

	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

	seq_ctl_t                  ctl;
	logic [SEC_W-1:0]          sec_idx;
	logic                      sample_xfer;
	logic                      out_hold;

	logic [CFG_DATA_W-1:0]     coef_q [SECTIONS];
	logic signed [COEF_W-1:0]  gain_q;
	logic [DATA_W-1:0]         d1_q [SECTIONS];
	logic [DATA_W-1:0]         d2_q [SECTIONS];

	logic [DATA_W-1:0]         x_q;
	logic [DATA_W-1:0]         w_acc_q;
	logic [DATA_W-1:0]         b_acc_q;
	logic [DATA_W-1:0]         prod_q;
	logic [DATA_W-1:0]         filtered_q;
	logic                      filtered_valid_q;

	logic [CFG_DATA_W-1:0]     cur_coef;
	logic [DATA_W-1:0]         cur_d1;
	logic [DATA_W-1:0]         cur_d2;
	logic signed [COEF_W-1:0]  mul_a_op;
	logic signed [DATA_W-1:0]  mul_b_op;
	logic [DATA_W-1:0]         prod_d;
	logic [DATA_W-1:0]         w_new;
	logic [DATA_W-1:0]         y_new;

	assign sample_xfer    = sample_valid && sample_ready;
	assign sample_ready   = !ctl.busy;
	assign out_hold       = filtered_valid_q && !filtered_ready;
	assign cfg_ready      = 1'b1;
	assign filtered_valid = filtered_valid_q;
	assign filtered       = filtered_q;

	cbbf_seq #(
		.SECTIONS (SECTIONS),
		.SEC_W    (SEC_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sample_xfer),
		.out_hold (out_hold),
		.ctl      (ctl),
		.sec_idx  (sec_idx)
	);

	// Coefficient registers; sections past the register list stay zero
	for (genvar s = 0; s < SECTIONS; s++) begin : g_coef
		if (s < NUM_COEF_REGS) begin : g_reg
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					coef_q[s] <= '0;
				end else if (cfg_valid && cfg_ready &&
				             cfg_index == REG_SECTION_ONE + CFG_IDX_W'(s)) begin
					coef_q[s] <= cfg_data;
				end
			end
		end else begin : g_zero
			assign coef_q[s] = '0;
		end
	end

	// Output gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= '0;
		end else if (cfg_valid && cfg_ready && cfg_index == REG_GAIN) begin
			gain_q <= cfg_data[COEF_W-1:0];
		end
	end

	// Select operands of the current section
	assign cur_coef = coef_q[sec_idx];
	assign cur_d1   = d1_q[sec_idx];
	assign cur_d2   = d2_q[sec_idx];

	always_comb begin
		unique case (ctl.uc.mul_a)
			MA_A1:   mul_a_op = cur_coef[3*COEF_W-1:2*COEF_W];
			MA_A2:   mul_a_op = cur_coef[4*COEF_W-1:3*COEF_W];
			MA_B1:   mul_a_op = cur_coef[COEF_W-1:0];
			MA_B2:   mul_a_op = cur_coef[2*COEF_W-1:COEF_W];
			MA_GAIN: mul_a_op = gain_q;
			default: mul_a_op = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.uc.mul_b)
			MB_D1:   mul_b_op = cur_d1;
			MB_D2:   mul_b_op = cur_d2;
			MB_BSUM: mul_b_op = b_acc_q;
			default: mul_b_op = '0;
		endcase
	end

	// Shared multiplier, low 32 bits of the signed product
	assign prod_d = DATA_W'(mul_a_op * mul_b_op);

	// Arithmetic shifts for the new delay and the section output
	assign w_new = DATA_W'($signed(w_acc_q) >>> FRAC_BITS);
	assign y_new = DATA_W'($signed(prod_q) >>> (2 * FRAC_BITS));

	// Datapath registers driven by the control word
	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			x_q <= DATA_W'(sample);
		end else if (ctl.exec && ctl.uc.x_load) begin
			x_q <= y_new;
		end
		if (ctl.exec && ctl.uc.mul_en) begin
			prod_q <= prod_d;
		end
		if (ctl.exec) begin
			unique case (ctl.uc.w_op)
				W_HOLD:   w_acc_q <= w_acc_q;
				W_LOAD_X: w_acc_q <= DATA_W'(x_q << FRAC_BITS);
				W_SUB:    w_acc_q <= w_acc_q - prod_q;
				default:  w_acc_q <= w_acc_q;
			endcase
			unique case (ctl.uc.b_op)
				B_HOLD:  b_acc_q <= b_acc_q;
				B_LOAD:  b_acc_q <= prod_q;
				B_ADD:   b_acc_q <= b_acc_q + prod_q;
				default: b_acc_q <= b_acc_q;
			endcase
		end
		if (ctl.finish) begin
			filtered_q <= y_new;
		end
	end

	// Section delays: shift d1 into d2 and load the new state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SECTIONS; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else if (ctl.exec && ctl.uc.shift_delays) begin
			d2_q[sec_idx] <= cur_d1;
			d1_q[sec_idx] <= w_new;
		end
	end

	// Output valid: set on the last step, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			filtered_valid_q <= 1'b1;
		end else if (filtered_ready) begin
			filtered_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		sample_xfer |=> !sample_ready)
		else $error("sample accepted while a sample is in flight");

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> filtered_valid)
		else $error("finished result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |-> (!filtered_valid || filtered_ready))
		else $error("pending result overwritten");

	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.busy |-> (sec_idx <= SEC_W'(SECTIONS - 1)))
		else $error("section index out of range");

	a_idle_no_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.busy |-> !ctl.exec && !ctl.finish)
		else $error("datapath active while sequencer idle");
`endif

endmodule
